// ===== hdl/batch_norm_weight_folding_unit_macros.svh =====
`ifndef BATCH_NORM_WEIGHT_FOLDING_UNIT_MACROS_SVH
`define BATCH_NORM_WEIGHT_FOLDING_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define BNWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BNWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bnwf_pkg.sv =====
package bnwf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int VAR_W         = 31;
    localparam int EPS_W         = 16;
    localparam int REG_IDX_W     = 1;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BN_ENABLE = 1'b0,
        REG_EPSILON   = 1'b1
    } reg_idx_t;

    // item opcodes, also used as result kind
    typedef enum logic [0:0] {
        OP_CHANNEL = 1'b0,
        OP_WEIGHT  = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DEN,
        ST_DIV,
        ST_ALPHA,
        ST_MUL,
        ST_FIX,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic sqrt_step;
        logic den_load;
        logic div_step;
        logic alpha_upd;
        logic mul_step;
        logic fix_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic en;
        logic op;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/bnwf_if.sv =====
// input item channel
interface bnwf_item_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [bnwf_pkg::DATA_W-1:0]  bias;
    logic signed [bnwf_pkg::DATA_W-1:0]  scale;
    logic signed [bnwf_pkg::DATA_W-1:0]  mean;
    logic        [bnwf_pkg::VAR_W-1:0]   variance;
    logic signed [bnwf_pkg::DATA_W-1:0]  weight;

    modport source (output valid, opcode, bias, scale, mean, variance, weight, input ready);
    modport sink (input valid, opcode, bias, scale, mean, variance, weight, output ready);
endinterface

// result channel
interface bnwf_result_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [bnwf_pkg::DATA_W-1:0]  value;

    modport source (output valid, kind, value, input ready);
    modport sink (input valid, kind, value, output ready);
endinterface

// configuration write channel
interface bnwf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bnwf_pkg::REG_IDX_W-1:0]      index;
    logic [bnwf_pkg::DATA_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bnwf_ctrl.sv =====
module bnwf_ctrl #(
    parameter int FRAC_BITS = bnwf_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  bnwf_pkg::status_t  status,
    output bnwf_pkg::cmd_t     cmd
);

    localparam int SQ_N  = (bnwf_pkg::VAR_W + FRAC_BITS + 1) / 2;
    localparam int DV_W  = bnwf_pkg::DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DV_W);

    bnwf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnwf_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            bnwf_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!status.en)
                        state_next = bnwf_pkg::ST_FIN;
                    else if (status.op == bnwf_pkg::OP_WEIGHT)
                        state_next = bnwf_pkg::ST_MUL;
                    else
                        state_next = bnwf_pkg::ST_SQRT;
                end
            end
            bnwf_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQ_N - 1))
                    state_next = bnwf_pkg::ST_DEN;
            end
            bnwf_pkg::ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = bnwf_pkg::ST_DIV;
            end
            bnwf_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DV_W - 1))
                    state_next = bnwf_pkg::ST_ALPHA;
            end
            bnwf_pkg::ST_ALPHA:
            begin
                cmd.alpha_upd = 1'b1;
                state_next    = bnwf_pkg::ST_MUL;
            end
            bnwf_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = bnwf_pkg::ST_FIX;
            end
            bnwf_pkg::ST_FIX:
            begin
                cmd.fix_step = 1'b1;
                state_next   = bnwf_pkg::ST_FIN;
            end
            bnwf_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bnwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnwf_pkg::ST_IDLE;
            end
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CNT_W'(1);
    end

endmodule

// ===== hdl/bnwf_dp.sv =====
module bnwf_dp #(
    parameter int FRAC_BITS = bnwf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bnwf_pkg::cmd_t                      cmd,
    output bnwf_pkg::status_t                   status,
    input  logic                                item_opcode,
    input  logic signed [bnwf_pkg::DATA_W-1:0]  item_bias,
    input  logic signed [bnwf_pkg::DATA_W-1:0]  item_scale,
    input  logic signed [bnwf_pkg::DATA_W-1:0]  item_mean,
    input  logic        [bnwf_pkg::VAR_W-1:0]   item_variance,
    input  logic signed [bnwf_pkg::DATA_W-1:0]  item_weight,
    input  logic                                cfg_we,
    input  logic [bnwf_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bnwf_pkg::DATA_W-1:0]         cfg_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                result_kind,
    output logic signed [bnwf_pkg::DATA_W-1:0]  result_value
);

    localparam int DW     = bnwf_pkg::DATA_W;
    localparam int SQ_W   = bnwf_pkg::VAR_W + FRAC_BITS;
    localparam int SQ_N   = (SQ_W + 1) / 2;
    localparam int RAD_W  = 2 * SQ_N;
    localparam int REM_W  = SQ_N + 2;
    localparam int DEN_W  = SQ_N + 1;
    localparam int DR_W   = DEN_W + 1;
    localparam int DV_W   = DW + FRAC_BITS;
    localparam int PROD_W = 2 * DW;
    localparam int TERM_W = PROD_W + 1;
    localparam int SUM_W  = TERM_W + 1;
    localparam logic signed [DW-1:0] ALPHA_ONE = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] SAT_MAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN   = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
        mag = x[DW-1] ? (DW'(0) - x) : x;
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [SUM_W-1:0] x);
        logic all0;
        logic all1;
        all0 = ~|x[SUM_W-1:DW-1];
        all1 = &x[SUM_W-1:DW-1];
        if (all0 || all1)
            sat = x[DW-1:0];
        else
            sat = x[SUM_W-1] ? SAT_MIN : SAT_MAX;
    endfunction

    logic                    en_cfg_reg;
    logic [bnwf_pkg::EPS_W-1:0] eps_reg;
    logic                    op_reg, en_reg;
    logic signed [DW-1:0]    bias_reg, scale_reg, mean_reg, weight_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [REM_W-1:0]        srem_reg;
    logic [SQ_N-1:0]         root_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DR_W-1:0]         drem_reg;
    logic [DV_W-1:0]         quo_reg;
    logic signed [DW-1:0]    alpha_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic                    out_valid_reg, out_kind_reg;
    logic signed [DW-1:0]    out_value_reg;

    logic [REM_W-1:0]        s_rem_t, s_trial;
    logic                    s_ge;
    logic [DEN_W-1:0]        den_sum;
    logic [DR_W-1:0]         d_rem_t, d_den;
    logic                    d_ge;
    logic                    q_big;
    logic [DW-1:0]           q_lo;
    logic signed [DW-1:0]    alpha_new;
    logic signed [DW-1:0]    mul_a;
    logic [PROD_W-1:0]       m_shift;
    logic signed [TERM_W-1:0] m_ext;
    logic signed [SUM_W-1:0] bias_diff;
    logic signed [DW-1:0]    res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_cfg_reg <= 1'b1;
            eps_reg    <= bnwf_pkg::EPS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (bnwf_pkg::reg_idx_t'(cfg_index))
                bnwf_pkg::REG_BN_ENABLE: en_cfg_reg <= cfg_data[0];
                bnwf_pkg::REG_EPSILON:   eps_reg    <= cfg_data[bnwf_pkg::EPS_W-1:0];
                default:                 en_cfg_reg <= en_cfg_reg;
            endcase
        end
    end

    // square root step: one result bit per cycle
    always_comb
    begin
        s_rem_t = {srem_reg[SQ_N-1:0], rad_reg[RAD_W-1 -: 2]};
        s_trial = {root_reg, 2'b01};
        s_ge    = s_rem_t >= s_trial;
    end

    // denominator sum; a zero sum is replaced by 1 when it is loaded
    assign den_sum = DEN_W'(root_reg) + DEN_W'(eps_reg);

    // divider step: one quotient bit per cycle
    always_comb
    begin
        d_rem_t = {drem_reg[DEN_W-1:0], quo_reg[DV_W-1]};
        d_den   = {1'b0, den_reg};
        d_ge    = d_rem_t >= d_den;
    end

    // signed, saturated folding factor from the quotient
    always_comb
    begin
        q_big = |quo_reg[DV_W-1:DW-1];
        q_lo  = {1'b0, quo_reg[DW-2:0]};
        if (scale_reg[DW-1])
            alpha_new = q_big ? SAT_MIN : $signed(DW'(0) - q_lo);
        else
            alpha_new = q_big ? SAT_MAX : $signed(q_lo);
    end

    // product shift and sign, bias subtraction, final result
    always_comb
    begin
        mul_a     = (op_reg == bnwf_pkg::OP_WEIGHT) ? weight_reg : mean_reg;
        m_shift   = prod_reg >> FRAC_BITS;
        m_ext     = $signed({1'b0, m_shift});
        bias_diff = SUM_W'(bias_reg) - SUM_W'(term_reg);
        if (!en_reg)
            res = (op_reg == bnwf_pkg::OP_WEIGHT) ? weight_reg : bias_reg;
        else if (op_reg == bnwf_pkg::OP_WEIGHT)
            res = sat(SUM_W'(term_reg));
        else
            res = sat(bias_diff);
    end

    // item capture and arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= item_opcode;
            en_reg     <= en_cfg_reg;
            bias_reg   <= item_bias;
            scale_reg  <= item_scale;
            mean_reg   <= item_mean;
            weight_reg <= item_weight;
            rad_reg    <= RAD_W'({item_variance, {FRAC_BITS{1'b0}}});
            srem_reg   <= '0;
            root_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            srem_reg <= s_ge ? (s_rem_t - s_trial) : s_rem_t;
            root_reg <= {root_reg[SQ_N-2:0], s_ge};
            rad_reg  <= rad_reg << 2;
        end
        if (cmd.den_load)
        begin
            den_reg  <= (den_sum == '0) ? DEN_W'(1) : den_sum;
            drem_reg <= '0;
            quo_reg  <= {mag(scale_reg), {FRAC_BITS{1'b0}}};
        end
        if (cmd.div_step)
        begin
            drem_reg <= d_ge ? (d_rem_t - d_den) : d_rem_t;
            quo_reg  <= {quo_reg[DV_W-2:0], d_ge};
        end
        if (cmd.mul_step)
        begin
            prod_reg <= PROD_W'(mag(mul_a)) * PROD_W'(mag(alpha_reg));
            neg_reg  <= mul_a[DW-1] ^ alpha_reg[DW-1];
        end
        if (cmd.fix_step)
            term_reg <= neg_reg ? (TERM_W'(0) - m_ext) : m_ext;
        if (cmd.out_load)
        begin
            out_kind_reg  <= op_reg;
            out_value_reg <= res;
        end
    end

    // folding factor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= ALPHA_ONE;
        else if (cmd.alpha_upd)
            alpha_reg <= alpha_new;
        else if (cmd.out_load && !en_reg && op_reg == bnwf_pkg::OP_CHANNEL)
            alpha_reg <= ALPHA_ONE;
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.en       = en_cfg_reg;
    assign status.op       = item_opcode;
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign result_value = out_value_reg;

endmodule

// ===== hdl/batch_norm_weight_folding_unit.sv =====
// Weight word, folding on: accept, multiply, sign fix, output load.
// Channel word, folding on: accept, square root, denominator, divider, alpha update,
// multiply, sign fix, output load; bit-serial square root and divider set the length.
// Folding off: accept, output load. A word is accepted only once the last one is loaded.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_n low, async): bn_enable 1, epsilon 1, alpha 1.0, no word pending.
module batch_norm_weight_folding_unit #(
    parameter int FRAC_BITS = bnwf_pkg::FRAC_BITS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    bnwf_item_if.sink        item,
    bnwf_result_if.source    result,
    bnwf_cfg_if.sink         cfg
);

    `include "batch_norm_weight_folding_unit_macros.svh"

    bnwf_pkg::cmd_t    cmd;
    bnwf_pkg::status_t status;
    logic              item_ready;

    // sequencer
    bnwf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // arithmetic and registers
    bnwf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .item_opcode   (item.opcode),
        .item_bias     (item.bias),
        .item_scale    (item.scale),
        .item_mean     (item.mean),
        .item_variance (item.variance),
        .item_weight   (item.weight),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .result_kind   (result.kind),
        .result_value  (result.value)
    );

    assign item.ready = item_ready;
    assign cfg.ready  = 1'b1;

    // checks
    `BNWF_ASSERT_NEXT(a_one_at_a_time, item.valid && item.ready, !item.ready, "item taken while busy")
    `BNWF_ASSERT_NOW(a_no_overwrite, cmd.out_load, status.out_free, "pending word overwritten")
    `BNWF_ASSERT_NOW(a_capture_idle, cmd.capture, item.valid && item_ready, "capture without handshake")

endmodule

// ===== verif/batch_norm_weight_folding_unit_tb.sv =====
module batch_norm_weight_folding_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC   = bnwf_pkg::FRAC_BITS_DEF;
    localparam int NRAND  = 850;
    localparam int LIMIT  = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam longint MAXP = 64'sd2147483647;
    localparam longint MINN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bnwf_item_if   item ();
    bnwf_result_if result ();
    bnwf_cfg_if    cfg ();

    batch_norm_weight_folding_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    typedef struct packed {
        bnwf_pkg::opcode_t   kind;
        logic signed [31:0]  value;
    } folded_t;

    typedef struct {
        bnwf_pkg::opcode_t   op;
        logic signed [31:0]  bias;
        logic signed [31:0]  scale;
        logic signed [31:0]  mean;
        logic        [30:0]  variance;
        logic signed [31:0]  weight;
        bit                  known;
        logic signed [31:0]  value;
    } stim_t;

    // predictor state
    bit                 fold_on;
    logic [15:0]        eps;
    logic signed [31:0] alpha_q;

    folded_t folded_q[$];
    bit      failed;
    longint  cycles;
    bit      hold_off;
    bit      hold_done;
    int      hold_len;
    int      stall_len;
    stim_t   directed[$];

    function automatic longint clamp32(longint x);
        if (x > MAXP)
            return MAXP;
        if (x < MINN)
            return MINN;
        return x;
    endfunction

    function automatic longint abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint m;
        m = (abs64(a) * abs64(b)) >>> FRAC;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // fold one accepted word; a channel word also updates alpha
    function automatic folded_t fold_word(stim_t s);
        folded_t f;
        longint den;
        longint q;
        longint a;
        f.kind = s.op;
        if (s.op == bnwf_pkg::OP_CHANNEL)
        begin
            if (fold_on)
            begin
                den = int_sqrt(longint'(s.variance) <<< FRAC) + longint'(eps);
                if (den == 0)
                    den = 1;
                q = (abs64(longint'(s.scale)) <<< FRAC) / den;
                if (q > 64'sd2147483648)
                    q = 64'sd2147483648;
                a = s.scale < 0 ? -q : q;
                alpha_q = 32'(clamp32(a));
                f.value = 32'(clamp32(longint'(s.bias) - fx_mul(s.mean, alpha_q)));
            end
            else
            begin
                alpha_q = 32'sd1 <<< FRAC;
                f.value = s.bias;
            end
        end
        else
            f.value = fold_on ? 32'(clamp32(fx_mul(s.weight, alpha_q))) : s.weight;
        return f;
    endfunction

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("batch_norm_weight_folding_unit_tb failed");
            $finish;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        folded_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (folded_q.size() == 0)
            begin
                $error("unexpected word kind=%0d value=%0d", result.kind, result.value);
                failed = 1'b1;
            end
            else
            begin
                want = folded_q.pop_front();
                if (result.kind !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, result.kind);
                    failed = 1'b1;
                end
                if (result.value !== want.value)
                begin
                    $error("value expected %0d actual %0d", want.value, result.value);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_len <= 0;
            hold_len <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_off && !hold_done)
        begin
            result.ready <= 1'b0;
            hold_len <= hold_len + 1;
            if (hold_len >= HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else if (stall_len > 0)
        begin
            stall_len <= stall_len - 1;
            result.ready <= 1'b0;
        end
        else if (cycles % 300 < 100)
            result.ready <= 1'b1;
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_len <= $urandom_range(0, 12);
            result.ready <= 1'b0;
        end
        else
            result.ready <= 1'b1;
    end

    task automatic put_word(stim_t s);
        item.valid    <= 1'b1;
        item.opcode   <= s.op;
        item.bias     <= s.bias;
        item.scale    <= s.scale;
        item.mean     <= s.mean;
        item.variance <= s.variance;
        item.weight   <= s.weight;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        folded_q.push_back(fold_word(s));
        if (s.known && folded_q[$].value !== s.value)
        begin
            $error("value expected %0d actual %0d", s.value, folded_q[$].value);
            failed = 1'b1;
        end
    endtask

    task automatic idle_gap(int n);
        item.valid <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    // wait until every result is in, plus slack for the slowest word
    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (folded_q.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    task automatic write_reg(bnwf_pkg::reg_idx_t idx, logic [31:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
        if (idx == bnwf_pkg::REG_BN_ENABLE)
            fold_on = d[0];
        else
            eps = d[15:0];
    endtask

    function automatic stim_t row(bnwf_pkg::opcode_t op, logic [31:0] b, logic [31:0] sc,
                                  logic [31:0] m, logic [30:0] v, logic [31:0] w,
                                  bit k, logic [31:0] val);
        stim_t s;
        s.op = op; s.bias = b; s.scale = sc; s.mean = m; s.variance = v;
        s.weight = w; s.known = k; s.value = val;
        return s;
    endfunction

    function automatic stim_t rand_word(int wshare);
        stim_t s;
        s.op = ($urandom_range(0, 99) < wshare) ? bnwf_pkg::OP_WEIGHT : bnwf_pkg::OP_CHANNEL;
        s.bias = $urandom();
        s.scale = ($urandom_range(0, 3) == 0) ? $urandom()
                : 32'($signed($urandom_range(0, 262143)) - 131072);
        s.mean = ($urandom_range(0, 3) == 0) ? $urandom()
               : 32'($signed($urandom_range(0, 262143)) - 131072);
        s.variance = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                   : 31'($urandom_range(0, 600000));
        s.weight = $urandom();
        s.known = 1'b0;
        s.value = '0;
        return s;
    endfunction

    // item source
    initial
    begin
        stim_t s;
        int burst;
        cycles = 0;
        failed = 1'b0;
        hold_off = 1'b0;
        fold_on = 1'b1;
        eps = 16'd1;
        alpha_q = 32'sd1 <<< FRAC;
        item.valid <= 1'b0;
        item.opcode <= bnwf_pkg::OP_CHANNEL;
        item.bias <= '0;
        item.scale <= '0;
        item.mean <= '0;
        item.variance <= '0;
        item.weight <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= bnwf_pkg::REG_BN_ENABLE;
        cfg.data <= '0;

        // directed table: weight before any channel uses alpha 1.0
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h0003_0000,
                               1, 32'h0003_0000));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h8000_0000,
                               1, 32'h8000_0000));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h7fff_ffff,
                               1, 32'h7fff_ffff));
        // variance 1.0, scale 1.0, mean 0: bias passes
        directed.push_back(row(bnwf_pkg::OP_CHANNEL, 32'h0001_0000, 32'h0001_0000, 0,
                               31'h0001_0000, 0, 0, 0));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'hffff_0000, 0, 0));
        // extremes saturate
        directed.push_back(row(bnwf_pkg::OP_CHANNEL, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 0, 0, 1, 32'h7fff_ffff));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h7fff_ffff,
                               1, 32'h7fff_ffff));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h8000_0000,
                               1, 32'h8000_0000));
        directed.push_back(row(bnwf_pkg::OP_CHANNEL, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 31'h7fff_ffff, 0, 0, 0));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0));
        directed.push_back(row(bnwf_pkg::OP_CHANNEL, 32'h1234_5678, 32'h0, 32'hffff_ffff,
                               31'h7fff_ffff, 32'hffff_ffff, 0, 0));
        directed.push_back(row(bnwf_pkg::OP_WEIGHT, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff, 31'h7fff_ffff, 32'h0, 1, 32'h0));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            put_word(directed[i]);
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 5));
        end
        drain();

        // zero denominator: epsilon 0, variance 0
        write_reg(bnwf_pkg::REG_EPSILON, 32'h0);
        put_word(row(bnwf_pkg::OP_CHANNEL, 32'h0000_0100, 32'h0000_0001, 32'h0001_0000,
                     0, 0, 0, 0));
        put_word(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h0001_0000, 0, 0));
        drain();
        // folding off: channel passes bias, weight passes through
        write_reg(bnwf_pkg::REG_BN_ENABLE, 32'h0);
        write_reg(bnwf_pkg::REG_EPSILON, 32'hffff);
        put_word(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h8000_0000, 1, 32'h8000_0000));
        put_word(row(bnwf_pkg::OP_CHANNEL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     31'h7fff_ffff, 0, 1, 32'h7fff_ffff));
        put_word(row(bnwf_pkg::OP_WEIGHT, 0, 0, 0, 0, 32'h1357_9bdf, 1, 32'h1357_9bdf));
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(bnwf_pkg::REG_BN_ENABLE, 32'h1);
                         write_reg(bnwf_pkg::REG_EPSILON, 32'h1); end
                1: begin write_reg(bnwf_pkg::REG_EPSILON, 32'hffff); end
                2: begin write_reg(bnwf_pkg::REG_BN_ENABLE, 32'h0); end
                3: begin write_reg(bnwf_pkg::REG_BN_ENABLE, 32'h1);
                         write_reg(bnwf_pkg::REG_EPSILON, 32'($urandom_range(0, 65535))); end
                default: begin write_reg(bnwf_pkg::REG_EPSILON, 32'h0); end
            endcase
            // long receiver hold-off while words keep coming
            if (ph == 1)
                hold_off = 1'b1;
            for (int n = 0; n < NRAND / 5; n += burst)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++)
                    put_word(rand_word(80));
                if ($urandom_range(0, 1) == 0)
                    idle_gap($urandom_range(1, 10));
            end
            hold_off = 1'b0;
            if (ph == 2)
            begin
                // sender pauses until every result is in, before the drain
                item.valid <= 1'b0;
                @(posedge clk);
                while (folded_q.size() != 0)
                    @(posedge clk);
            end
            drain();
        end

        if (!failed)
            $display("batch_norm_weight_folding_unit_tb passed");
        else
            $display("batch_norm_weight_folding_unit_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bnwf_pkg.sv
hdl/bnwf_if.sv
hdl/bnwf_ctrl.sv
hdl/bnwf_dp.sv
hdl/batch_norm_weight_folding_unit.sv
verif/batch_norm_weight_folding_unit_tb.sv
